// ===== hw/rtl/lsa_pkg.sv =====
// Shared constants and types for the LRU slot assigner.
// No dependencies; every other file in hw/rtl uses this package.
`default_nettype none

package lsa_pkg;

  // Default number of slots in the table.
  localparam int unsigned MAX_SLOTS_DEF = 8;

  // Field widths fixed by the request and result formats.
  localparam int unsigned OWNER_W   = 32;
  localparam int unsigned ACTIVE_W  = 4;
  localparam int unsigned SLOT_IDX_W = 3;
  localparam int unsigned OUTCOME_W = 2;

  // Value of the active slot count after reset.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_CLAIM = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_ERROR = 2'd3
  } outcome_e;

endpackage

`default_nettype wire

// ===== hw/rtl/lsa_if.sv =====
// Handshake channels of the LRU slot assigner: request, result and configuration.
// Depends on lsa_pkg for the field widths.
`default_nettype none

interface lsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [lsa_pkg::OWNER_W-1:0]  owner_id;

  modport source (output valid, output owner_id, input ready);
  modport sink   (input valid, input owner_id, output ready);
endinterface

interface lsa_res_if;
  logic                            valid;
  logic                            ready;
  logic [lsa_pkg::SLOT_IDX_W-1:0]  slot_index;
  logic [lsa_pkg::OUTCOME_W-1:0]   outcome;
  logic [lsa_pkg::OWNER_W-1:0]     evicted_owner;

  modport source (output valid, output slot_index, output outcome, output evicted_owner,
                  input ready);
  modport sink   (input valid, input slot_index, input outcome, input evicted_owner,
                  output ready);
endinterface

interface lsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lsa_pkg::ACTIVE_W-1:0]  active_slots;

  modport source (output valid, output active_slots, input ready);
  modport sink   (input valid, input active_slots, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsa_table.sv =====
// Slot table: one synchronous memory holding each slot's owner and recency rank.
// One read and one write port, registered read data. Depends on lsa_pkg.
`default_nettype none

module lsa_table #(
  parameter int unsigned Depth = lsa_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       rd_en_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output      logic [lsa_pkg::OWNER_W-1:0]                rd_owner_o,
  output      logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_rank_o,
  input  wire logic                                       wr_en_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  wire logic [lsa_pkg::OWNER_W-1:0]                wr_owner_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_rank_i
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntryW = lsa_pkg::OWNER_W + AddrW;

  logic [EntryW-1:0] mem [Depth];
  logic [Depth-1:0]  written_q;
  logic [EntryW-1:0] rd_data_q;
  logic              rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_owner_i, wr_rank_i};
    end
  end

  // An entry that was never written reads as a free slot with rank zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q    <= mem[rd_addr_i];
      rd_written_q <= written_q[rd_addr_i];
    end
  end

  assign rd_owner_o = rd_written_q ? rd_data_q[EntryW-1:AddrW] : '0;
  assign rd_rank_o  = rd_written_q ? rd_data_q[AddrW-1:0] : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_slot_assigner_top.sv =====
// Top level of the LRU slot assigner: request, result and configuration channels,
// the scan and update sequencer and the result register. Depends on lsa_pkg,
// the interfaces in lsa_if and lsa_table.
//
// Usage: each request carries an owner id and returns exactly one result with the
// slot given to that owner, the outcome (hit, free slot claimed, LRU slot evicted,
// or error) and the evicted owner. Requests are taken one at a time.
// Sequence: the idle state takes the request, the scan state then examines one
// active slot per cycle (the scan stops early on a hit), the sweep state rewrites
// every table entry with its new owner and age, and the finish state loads the
// result register. The single read port of the slot table is why the entries
// are visited one at a time. An owner of zero or zero active slots skips the
// table and goes straight to the finish state, which gives an error result.
// Reset empties every slot and sets the active slot count to eight.
// A stalled receiver holds the result register; a finished item then waits for it
// and no new request is taken. The configuration channel is always ready; the user
// must write it only while no request is in flight, as the block does not enforce it.
`default_nettype none

module lru_slot_assigner_top #(
  parameter int unsigned MaxSlots = lsa_pkg::MAX_SLOTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lsa_req_if.sink    req_i,
  lsa_res_if.source  res_o,
  lsa_cfg_if.sink    cfg_i
);

  localparam int unsigned SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW  = $clog2(MaxSlots + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [lsa_pkg::ACTIVE_W-1:0]    active_q;
  logic [lsa_pkg::OWNER_W-1:0]     owner_q, owner_d;
  logic [CntW-1:0]                 n_q, n_d;
  logic [SlotW-1:0]                idx_q, idx_d;
  logic                            free_found_q, free_found_d;
  logic [SlotW-1:0]                free_idx_q, free_idx_d;
  logic [SlotW-1:0]                vic_idx_q, vic_idx_d;
  logic [SlotW-1:0]                vic_rank_q, vic_rank_d;
  logic [lsa_pkg::OWNER_W-1:0]     vic_owner_q, vic_owner_d;
  logic [SlotW-1:0]                sel_q, sel_d;
  logic [SlotW-1:0]                limit_q, limit_d;
  logic                            age_all_q, age_all_d;
  lsa_pkg::outcome_e               outcome_q, outcome_d;
  logic [lsa_pkg::OWNER_W-1:0]     evicted_q, evicted_d;

  logic                            res_valid_q, res_valid_d;
  logic [lsa_pkg::SLOT_IDX_W-1:0]  res_slot_q, res_slot_d;
  lsa_pkg::outcome_e               res_outcome_q, res_outcome_d;
  logic [lsa_pkg::OWNER_W-1:0]     res_evicted_q, res_evicted_d;

  logic [CntW-1:0]                 n_sat;
  logic                            rd_en;
  logic [SlotW-1:0]                rd_addr;
  logic [lsa_pkg::OWNER_W-1:0]     rd_owner;
  logic [SlotW-1:0]                rd_rank;
  logic                            wr_en;
  logic [lsa_pkg::OWNER_W-1:0]     wr_owner;
  logic [SlotW-1:0]                wr_rank;

  logic                            scan_last;
  logic                            free_now;
  logic [SlotW-1:0]                free_idx_n;
  logic                            take_vic;
  logic [SlotW-1:0]                vic_idx_n;
  logic [SlotW-1:0]                vic_rank_n;
  logic [lsa_pkg::OWNER_W-1:0]     vic_owner_n;

  lsa_table #(
    .Depth (MaxSlots)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_owner_o (rd_owner),
    .rd_rank_o  (rd_rank),
    .wr_en_i    (wr_en),
    .wr_addr_i  (idx_q),
    .wr_owner_i (wr_owner),
    .wr_rank_i  (wr_rank)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);

  assign res_o.valid         = res_valid_q;
  assign res_o.slot_index    = res_slot_q;
  assign res_o.outcome       = res_outcome_q;
  assign res_o.evicted_owner = res_evicted_q;

  always_comb begin
    if (32'(active_q) > 32'(MaxSlots)) begin
      n_sat = CntW'(MaxSlots);
    end else begin
      n_sat = CntW'(active_q);
    end
  end

  // Scan bookkeeping for the entry whose read data is present this cycle.
  always_comb begin
    scan_last   = ((CntW'(idx_q) + CntW'(1)) == n_q);
    free_now    = free_found_q || (rd_owner == '0);
    free_idx_n  = free_found_q ? free_idx_q : idx_q;
    take_vic    = (idx_q == '0) || (rd_rank > vic_rank_q);
    vic_idx_n   = take_vic ? idx_q : vic_idx_q;
    vic_rank_n  = take_vic ? rd_rank : vic_rank_q;
    vic_owner_n = take_vic ? rd_owner : vic_owner_q;
  end

  // Rewrite of one entry during the sweep: the chosen slot becomes the youngest,
  // other occupied slots younger than the limit, or all of them on a claim, age by one.
  always_comb begin
    if (idx_q == sel_q) begin
      wr_owner = owner_q;
      wr_rank  = '0;
    end else begin
      wr_owner = rd_owner;
      if ((rd_owner != '0) && (age_all_q || (rd_rank < limit_q))) begin
        wr_rank = rd_rank + SlotW'(1);
      end else begin
        wr_rank = rd_rank;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    owner_d       = owner_q;
    n_d           = n_q;
    idx_d         = idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    vic_idx_d     = vic_idx_q;
    vic_rank_d    = vic_rank_q;
    vic_owner_d   = vic_owner_q;
    sel_d         = sel_q;
    limit_d       = limit_q;
    age_all_d     = age_all_q;
    outcome_d     = outcome_q;
    evicted_d     = evicted_q;
    res_valid_d   = res_valid_q && !res_o.ready;
    res_slot_d    = res_slot_q;
    res_outcome_d = res_outcome_q;
    res_evicted_d = res_evicted_q;
    rd_en         = 1'b0;
    rd_addr       = idx_q + SlotW'(1);
    wr_en         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          owner_d = req_i.owner_id;
          n_d     = n_sat;
          if ((n_sat == '0) || (req_i.owner_id == '0)) begin
            sel_d     = '0;
            outcome_d = lsa_pkg::OUT_ERROR;
            evicted_d = '0;
            state_d   = ST_FIN;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            idx_d        = '0;
            free_found_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_owner == owner_q) begin
          sel_d     = idx_q;
          limit_d   = rd_rank;
          age_all_d = 1'b0;
          outcome_d = lsa_pkg::OUT_HIT;
          evicted_d = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_d     = '0;
          state_d   = ST_SWEEP;
        end else if (scan_last) begin
          if (free_now) begin
            sel_d     = free_idx_n;
            age_all_d = 1'b1;
            outcome_d = lsa_pkg::OUT_CLAIM;
            evicted_d = '0;
          end else begin
            sel_d     = vic_idx_n;
            limit_d   = vic_rank_n;
            age_all_d = 1'b0;
            outcome_d = lsa_pkg::OUT_EVICT;
            evicted_d = vic_owner_n;
          end
          rd_en   = 1'b1;
          rd_addr = '0;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end else begin
          free_found_d = free_now;
          free_idx_d   = free_idx_n;
          vic_idx_d    = vic_idx_n;
          vic_rank_d   = vic_rank_n;
          vic_owner_d  = vic_owner_n;
          rd_en        = 1'b1;
          idx_d        = idx_q + SlotW'(1);
        end
      end

      ST_SWEEP: begin
        wr_en = 1'b1;
        if (idx_q == SlotW'(MaxSlots - 1)) begin
          state_d = ST_FIN;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + SlotW'(1);
        end
      end

      ST_FIN: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d   = 1'b1;
          res_slot_d    = lsa_pkg::SLOT_IDX_W'(sel_q);
          res_outcome_d = outcome_q;
          res_evicted_d = evicted_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= lsa_pkg::ACTIVE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        active_q <= cfg_i.active_slots;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q       <= owner_d;
    n_q           <= n_d;
    idx_q         <= idx_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    vic_idx_q     <= vic_idx_d;
    vic_rank_q    <= vic_rank_d;
    vic_owner_q   <= vic_owner_d;
    sel_q         <= sel_d;
    limit_q       <= limit_d;
    age_all_q     <= age_all_d;
    outcome_q     <= outcome_d;
    evicted_q     <= evicted_d;
    res_slot_q    <= res_slot_d;
    res_outcome_q <= res_outcome_d;
    res_evicted_q <= res_evicted_d;
  end

endmodule

`default_nettype wire

// ===== tb/tb_lru_slot_assigner_top.sv =====
// Self-checking testbench for lru_slot_assigner_top: directed table, then random owner traffic.
// Depends on lsa_pkg, the channel interfaces in lsa_if and the block itself;
// expected grants come from an LRU table model kept here.
`timescale 1ns / 100ps

module tb_lru_slot_assigner_top;
  import lsa_pkg::*;

  localparam int unsigned NUM_SLOTS    = MAX_SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned OWNER_POOL   = 11;
  localparam int unsigned PRINT_CAP    = 100;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    outcome_e              outcome;
    logic [OWNER_W-1:0]    evicted;
  } slot_grant_t;

  typedef struct packed {
    logic               is_cfg;
    logic [OWNER_W-1:0] value;
    logic               fixed;
    slot_grant_t        want;
  } stim_row_t;

  localparam slot_grant_t NO_GRANT = '{3'd0, OUT_HIT, 32'h0};

  // Rows marked fixed carry a hand-worked grant; the rest use the table model.
  localparam stim_row_t DIRECTED [26] = '{
    '{1'b0, 32'h0000_0000, 1'b1, '{3'd0, OUT_ERROR, 32'h0}},
    '{1'b0, 32'h0000_0001, 1'b1, '{3'd0, OUT_CLAIM, 32'h0}},
    '{1'b1, 32'h0000_0002, 1'b0, NO_GRANT},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, '{3'd1, OUT_CLAIM, 32'h0}},
    '{1'b0, 32'h8000_0000, 1'b1, '{3'd0, OUT_EVICT, 32'h1}},
    '{1'b0, 32'h0000_0001, 1'b1, '{3'd1, OUT_EVICT, 32'hFFFF_FFFF}},
    '{1'b0, 32'h0000_0001, 1'b1, '{3'd1, OUT_HIT, 32'h0}},
    '{1'b1, 32'h0000_0000, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0005, 1'b1, '{3'd0, OUT_ERROR, 32'h0}},
    '{1'b1, 32'h0000_000F, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0002, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0003, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0004, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0005, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0006, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0007, 1'b0, NO_GRANT},
    '{1'b0, 32'h8000_0000, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0009, 1'b0, NO_GRANT},
    '{1'b1, 32'h0000_0001, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0001, 1'b0, NO_GRANT},
    '{1'b1, 32'h0000_0003, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0006, 1'b0, NO_GRANT},
    '{1'b1, 32'h0000_0008, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0006, 1'b0, NO_GRANT},
    '{1'b0, 32'h0000_0000, 1'b1, '{3'd0, OUT_ERROR, 32'h0}},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, NO_GRANT}
  };

  localparam logic [ACTIVE_W-1:0] CFG_SWEEP [4] = '{4'd8, 4'd0, 4'd15, 4'd1};

  logic clk_i;
  logic rst_ni;

  lsa_req_if req_if ();
  lsa_res_if res_if ();
  lsa_cfg_if cfg_if ();

  lru_slot_assigner_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Model of the slot table.
  logic [OWNER_W-1:0] owner_tbl [NUM_SLOTS];
  int unsigned        age_tbl   [NUM_SLOTS];
  int unsigned        active_cnt;

  slot_grant_t expected_grants [$];
  int unsigned err_cnt;
  int unsigned grants_seen;
  int unsigned cycle_cnt;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Ages every occupied slot younger than limit, inactive ones included.
  function automatic void touch_slot(input int unsigned s, input int unsigned limit);
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      if (i != s && owner_tbl[i] != '0 && age_tbl[i] < limit) age_tbl[i]++;
    end
    age_tbl[s] = 0;
  endfunction

  function automatic slot_grant_t assign_slot(input logic [OWNER_W-1:0] owner);
    slot_grant_t g;
    int unsigned n;
    int unsigned hit_idx;
    int unsigned free_idx;
    int unsigned victim;
    bit          found;
    bit          have_free;
    g = '{'0, OUT_ERROR, '0};
    n = (active_cnt > NUM_SLOTS) ? NUM_SLOTS : active_cnt;
    found = 1'b0;
    have_free = 1'b0;
    hit_idx = 0;
    free_idx = 0;
    victim = 0;
    if (n == 0 || owner == '0) return g;
    for (int unsigned i = 0; i < n; i++) begin
      if (owner_tbl[i] == owner) begin
        found = 1'b1;
        hit_idx = i;
        break;
      end
      if (owner_tbl[i] == '0 && !have_free) begin
        have_free = 1'b1;
        free_idx = i;
      end
    end
    if (found) begin
      touch_slot(hit_idx, age_tbl[hit_idx]);
      g.slot = SLOT_IDX_W'(hit_idx);
      g.outcome = OUT_HIT;
    end else if (have_free) begin
      touch_slot(free_idx, 32'hFFFF_FFFF);
      owner_tbl[free_idx] = owner;
      g.slot = SLOT_IDX_W'(free_idx);
      g.outcome = OUT_CLAIM;
    end else begin
      // The first active slot with the greatest age is the victim.
      for (int unsigned i = 1; i < n; i++) begin
        if (age_tbl[i] > age_tbl[victim]) victim = i;
      end
      g.evicted = owner_tbl[victim];
      touch_slot(victim, age_tbl[victim]);
      owner_tbl[victim] = owner;
      g.slot = SLOT_IDX_W'(victim);
      g.outcome = OUT_EVICT;
    end
    return g;
  endfunction

  task automatic flag_mismatch(input string what, input logic [OWNER_W-1:0] got,
                               input logic [OWNER_W-1:0] want);
    err_cnt++;
    // Printing stops after a while so a dead block does not flood the log.
    if (err_cnt <= PRINT_CAP) begin
      $display("%0t result %0d: %s got %0h expected %0h", $realtime, grants_seen, what, got,
               want);
    end
  endtask

  // Valid stays high across back-to-back requests; it only drops before a gap.
  task automatic put_request(input logic [OWNER_W-1:0] owner, input logic use_row,
                             input slot_grant_t row_want);
    slot_grant_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.owner_id <= owner;
    do @(posedge clk_i); while (!req_if.ready);
    want = assign_slot(owner);
    expected_grants.push_back(use_row ? row_want : want);
  endtask

  // The register is only written once every request has returned its result.
  task automatic write_active(input logic [ACTIVE_W-1:0] value);
    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.active_slots <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    active_cnt = 32'(value);
  endtask

  initial begin : result_sink
    slot_grant_t want;
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          flag_mismatch("result with no request pending", OWNER_W'(res_if.slot_index), '0);
        end else begin
          want = expected_grants.pop_front();
          if (res_if.slot_index !== want.slot)
            flag_mismatch("slot_index", OWNER_W'(res_if.slot_index), OWNER_W'(want.slot));
          if (res_if.outcome !== want.outcome)
            flag_mismatch("outcome", OWNER_W'(res_if.outcome), OWNER_W'(want.outcome));
          if (res_if.evicted_owner !== want.evicted)
            flag_mismatch("evicted_owner", res_if.evicted_owner, want.evicted);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  initial begin : stimulus
    logic [OWNER_W-1:0]  owner_pool [OWNER_POOL];
    logic [OWNER_W-1:0]  owner;
    logic [ACTIVE_W-1:0] cfg_val;
    int unsigned         sent;
    int unsigned         phase;
    int unsigned         span;
    int unsigned         pick;
    err_cnt = 0;
    grants_seen = 0;
    idle_on = 1'b1;
    active_cnt = 32'(ACTIVE_RESET);
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      owner_tbl[i] = '0;
      age_tbl[i] = 0;
    end
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.owner_id     <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.active_slots <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg) write_active(DIRECTED[r].value[ACTIVE_W-1:0]);
      else put_request(DIRECTED[r].value, DIRECTED[r].fixed, DIRECTED[r].want);
    end

    // A small pool of owners keeps hits and evictions frequent; the pool is
    // a little larger than the table so the LRU order matters.
    for (int unsigned i = 0; i < OWNER_POOL; i++) begin
      do owner_pool[i] = $urandom; while (owner_pool[i] == '0);
    end
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      cfg_val = (phase < 4) ? CFG_SWEEP[phase] : ACTIVE_W'($urandom_range(0, 15));
      write_active(cfg_val);
      span = (cfg_val == '0) ? 15 : $urandom_range(80, 200);
      for (int unsigned k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 3) owner = '0;
        else if (pick < 15) owner = $urandom;
        else owner = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
        put_request(owner, 1'b0, NO_GRANT);
        sent++;
      end
      phase++;
    end

    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lsa_pkg.sv
hw/rtl/lsa_if.sv
hw/rtl/lsa_table.sv
hw/rtl/lru_slot_assigner_top.sv
tb/tb_lru_slot_assigner_top.sv
